>>> sv/tap_pulse_rate_meter_top_defines.svh
// Assertion macros used by the datapath RTL of the pulse rate meter.
`ifndef TAP_PULSE_RATE_METER_TOP_DEFINES_SVH
`define TAP_PULSE_RATE_METER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TPRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define TPRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TPRM_ASSERT(lbl, prop, msg)

`define TPRM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/tprm_pkg.sv
package tprm_pkg;

    localparam int BEAT_DEPTH_DEF = 20;

    localparam int TIME_W    = 32;
    localparam int GAP_W     = 16;
    localparam int WIN_W     = 20;
    localparam int PERIOD_W  = 16;
    localparam int RATE_W    = 16;
    localparam int HELD_W    = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    // Tenths of a beat per minute for one interval of one millisecond.
    localparam int RATE_SCALE = 600000;

    localparam logic [RATE_W-1:0]   RATE_MAX         = 16'hFFFF;
    localparam logic [GAP_W-1:0]    MIN_GAP_RST      = 16'd300;
    localparam logic [WIN_W-1:0]    WINDOW_RST       = 20'd10000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST       = 16'd1000;
    localparam logic [RATE_W-1:0]   RATE_FLOOR_RST   = 16'd300;
    localparam logic [RATE_W-1:0]   RATE_CEILING_RST = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_GAP      = 3'd0,
        CFG_WINDOW       = 3'd1,
        CFG_PERIOD       = 3'd2,
        CFG_RATE_FLOOR   = 3'd3,
        CFG_RATE_CEILING = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic capture;
        logic decide;
        logic ev_read;
        logic ev_step;
        logic div_load;
        logic div_step;
        logic rate_store;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic beat;
        logic count_gt1;
        logic evict;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

>>> sv/tap_pulse_rate_meter_top.sv
// Pulse rate meter driven by polls of a tap sensor.
//
// The slave stream carries one request per poll: the active-low sensor level
// and a wrapping millisecond time. Every accepted request yields exactly one
// result on the master stream: the held rate in tenths of a beat per minute,
// the beat, update and report flags, the range flag and the number of beats
// stored. Configuration is written through the plain write port while idle;
// the user must keep to this, as the block itself does not enforce it.
// A request that takes no beat goes from capture through the decide step to
// publishing. A beat that recomputes the rate reads the oldest stored beat and
// drops each one that falls out of the window, each check reading the beat
// memory once; it then runs the restoring divider over a numerator of NumW
// bits (24 bits at the default depth, one quotient bit per cycle), stores the
// rate and publishes it. One request is in flight at a time; the next is
// accepted as soon as the result sits in the output register. If the receiver
// stalls, the result is held and the block stops accepting once the next
// result is ready. Reset empties the beat ring, clears the rate and restores
// the default register values; the beat memory itself needs no clearing.
module tap_pulse_rate_meter_top #(
    parameter int BEAT_DEPTH = tprm_pkg::BEAT_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [0] sensor_level, [32:1] now_ms, [39:33] zero.
    input  logic [tprm_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [15:0] rate_tenths, [16] beat_taken, [17] rate_updated, [18] report_tick,
    // [19] rate_in_range, [26:20] beats_held, [31:27] zero.
    output logic [tprm_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [tprm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tprm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    tprm_pkg::t_cmd cmd;
    tprm_pkg::t_sts sts;

    tprm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tprm_dp #(
        .BEAT_DEPTH (BEAT_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

>>> sv/tprm_ram.sv
module tprm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/tprm_ctrl.sv
module tprm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tprm_pkg::t_sts  i_sts,
    output tprm_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_EV_RD,
        S_EV_CHK,
        S_DIV,
        S_STORE,
        S_PUB
    } t_state;

    t_state         r_state;
    t_state         n_state;
    tprm_pkg::t_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                n_state    = i_sts.beat ? S_EV_RD : S_PUB;
            end
            S_EV_RD: begin
                if (i_sts.count_gt1) begin
                    cmd.ev_read = 1'b1;
                    n_state     = S_EV_CHK;
                end else begin
                    n_state = S_PUB;
                end
            end
            S_EV_CHK: begin
                if (i_sts.evict) begin
                    cmd.ev_step = 1'b1;
                    n_state     = S_EV_RD;
                end else begin
                    cmd.div_load = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                cmd.rate_store = 1'b1;
                n_state        = S_PUB;
            end
            S_PUB: begin
                if (i_sts.out_free) begin
                    cmd.publish = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

>>> sv/tprm_dp.sv
`include "tap_pulse_rate_meter_top_defines.svh"

module tprm_dp #(
    parameter int BEAT_DEPTH = tprm_pkg::BEAT_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [tprm_pkg::IN_TDATA_W-1:0]   i_in_data,
    input  logic                              i_cfg_wr_en,
    input  logic [tprm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tprm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [tprm_pkg::OUT_TDATA_W-1:0]  o_out_data,
    input  tprm_pkg::t_cmd                    i_cmd,
    output tprm_pkg::t_sts                    o_sts
);

    localparam int AddrW   = $clog2(BEAT_DEPTH);
    localparam int CntW    = $clog2(BEAT_DEPTH + 1);
    localparam int SumW    = AddrW + 2;
    localparam int NumW    = $clog2(tprm_pkg::RATE_SCALE * (BEAT_DEPTH - 1) + 1);
    localparam int DivCntW = $clog2(NumW);
    localparam int TimeW   = tprm_pkg::TIME_W;
    localparam int RateW   = tprm_pkg::RATE_W;
    localparam int HeldW   = tprm_pkg::HELD_W;

    logic [tprm_pkg::GAP_W-1:0]    r_min_gap;
    logic [tprm_pkg::WIN_W-1:0]    r_window;
    logic [tprm_pkg::PERIOD_W-1:0] r_period;
    logic [RateW-1:0]              r_floor;
    logic [RateW-1:0]              r_ceiling;

    logic [CntW-1:0]    r_count;
    logic [AddrW-1:0]   r_oldest;
    logic [TimeW-1:0]   r_last_beat;
    logic [TimeW-1:0]   r_last_report;
    logic               r_armed;
    logic [RateW-1:0]   r_rate;

    logic               r_level;
    logic [TimeW-1:0]   r_now;
    logic               r_taken;
    logic               r_updated;
    logic               r_tick;

    logic [NumW-1:0]    r_num;
    logic [TimeW-1:0]   r_span;
    logic [TimeW-1:0]   r_rem;
    logic [DivCntW-1:0] r_div_cnt;

    logic                              r_out_valid;
    logic [tprm_pkg::OUT_TDATA_W-1:0]  r_out_data;

    logic               tap_edge;
    logic               gap_ok;
    logic               tick_due;
    logic               ring_full;
    logic [SumW-1:0]    tail_sum;
    logic [SumW-1:0]    next_sum;
    logic [AddrW-1:0]   tail_slot;
    logic [AddrW-1:0]   next_slot;
    logic               ram_wr_en;
    logic [AddrW-1:0]   ram_wr_addr;
    logic [TimeW-1:0]   ram_rd_data;
    logic [TimeW:0]     rem_sh;
    logic               div_ge;
    logic               in_range;

    tprm_ram #(
        .WIDTH (TimeW),
        .DEPTH (BEAT_DEPTH)
    ) u_beat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_now),
        .i_rd_en   (i_cmd.ev_read),
        .i_rd_addr (r_oldest),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        tap_edge  = !r_level && !r_armed;
        gap_ok    = (r_now - r_last_beat) >= TimeW'(r_min_gap);
        tick_due  = (r_now - r_last_report) > TimeW'(r_period);
        ring_full = (r_count == CntW'(BEAT_DEPTH));

        tail_sum  = SumW'(r_oldest) + SumW'(r_count);
        if (tail_sum >= SumW'(BEAT_DEPTH)) begin
            tail_sum = tail_sum - SumW'(BEAT_DEPTH);
        end
        tail_slot = tail_sum[AddrW-1:0];

        next_sum  = SumW'(r_oldest) + SumW'(1);
        if (next_sum >= SumW'(BEAT_DEPTH)) begin
            next_sum = next_sum - SumW'(BEAT_DEPTH);
        end
        next_slot = next_sum[AddrW-1:0];

        ram_wr_en   = i_cmd.decide && tap_edge && gap_ok;
        ram_wr_addr = ring_full ? r_oldest : tail_slot;

        rem_sh = {r_rem, r_num[NumW-1]};
        div_ge = rem_sh >= {1'b0, r_span};

        in_range = (r_rate > r_floor) && (r_rate < r_ceiling);

        o_sts.beat      = tap_edge && gap_ok;
        o_sts.count_gt1 = r_count > CntW'(1);
        o_sts.evict     = (r_now - ram_rd_data) > TimeW'(r_window);
        o_sts.div_last  = (r_div_cnt == DivCntW'(NumW - 1));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap     <= tprm_pkg::MIN_GAP_RST;
            r_window      <= tprm_pkg::WINDOW_RST;
            r_period      <= tprm_pkg::PERIOD_RST;
            r_floor       <= tprm_pkg::RATE_FLOOR_RST;
            r_ceiling     <= tprm_pkg::RATE_CEILING_RST;
            r_count       <= '0;
            r_oldest      <= '0;
            r_last_beat   <= '0;
            r_last_report <= '0;
            r_armed       <= 1'b0;
            r_rate        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    tprm_pkg::CFG_MIN_GAP:      r_min_gap <= i_cfg_wdata[tprm_pkg::GAP_W-1:0];
                    tprm_pkg::CFG_WINDOW:       r_window  <= i_cfg_wdata[tprm_pkg::WIN_W-1:0];
                    tprm_pkg::CFG_PERIOD:       r_period  <= i_cfg_wdata[tprm_pkg::PERIOD_W-1:0];
                    tprm_pkg::CFG_RATE_FLOOR:   r_floor   <= i_cfg_wdata[RateW-1:0];
                    tprm_pkg::CFG_RATE_CEILING: r_ceiling <= i_cfg_wdata[RateW-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.decide) begin
                if (tap_edge) begin
                    r_armed <= 1'b1;
                end
                if (r_level) begin
                    r_armed <= 1'b0;
                end
                if (tick_due) begin
                    r_last_report <= r_now;
                end
                if (tap_edge && gap_ok) begin
                    r_last_beat <= r_now;
                    if (ring_full) begin
                        r_oldest <= next_slot;
                    end else begin
                        r_count <= r_count + CntW'(1);
                    end
                end
            end

            if (i_cmd.ev_step) begin
                r_oldest <= next_slot;
                r_count  <= r_count - CntW'(1);
            end

            if (i_cmd.rate_store) begin
                if (r_span == '0 || r_num > NumW'(tprm_pkg::RATE_MAX)) begin
                    r_rate <= tprm_pkg::RATE_MAX;
                end else begin
                    r_rate <= r_num[RateW-1:0];
                end
            end

            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_level   <= i_in_data[0];
            r_now     <= i_in_data[TimeW:1];
            r_taken   <= 1'b0;
            r_updated <= 1'b0;
            r_tick    <= 1'b0;
        end
        if (i_cmd.decide) begin
            r_taken <= tap_edge && gap_ok;
            r_tick  <= tick_due;
        end
        if (i_cmd.div_load) begin
            r_num     <= NumW'(tprm_pkg::RATE_SCALE) * NumW'(r_count - CntW'(1));
            r_span    <= r_now - ram_rd_data;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= div_ge ? TimeW'(rem_sh - {1'b0, r_span}) : rem_sh[TimeW-1:0];
            r_num     <= {r_num[NumW-2:0], div_ge};
            r_div_cnt <= r_div_cnt + DivCntW'(1);
        end
        if (i_cmd.rate_store) begin
            r_updated <= 1'b1;
        end
        if (i_cmd.publish) begin
            r_out_data <= {5'b0, HeldW'(r_count), in_range, r_tick, r_updated, r_taken,
                           r_rate};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `TPRM_ASSERT(a_count_bound, r_count <= CntW'(BEAT_DEPTH), "beat count above ring depth")
    `TPRM_ASSERT(a_oldest_bound, r_oldest < AddrW'(BEAT_DEPTH), "oldest slot outside ring")
    `TPRM_ASSERT(a_evict_keeps_one, i_cmd.ev_step |-> r_count > CntW'(1),
                 "eviction would drop the last beat")
    `TPRM_ASSERT(a_update_needs_beat, r_out_valid && r_out_data[17] |-> r_out_data[16],
                 "rate update published without a beat")
    `TPRM_ASSERT_NEXT(a_beat_holds_count, i_cmd.decide && tap_edge && gap_ok,
                      r_count != '0, "beat taken but ring empty")

endmodule

>>> tb/tap_pulse_rate_meter_top_tb.sv
module tap_pulse_rate_meter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tprm_pkg::*;

    localparam int          RING_DEPTH    = BEAT_DEPTH_DEF;
    localparam int          LONG_HOLD     = 300;
    localparam int          DRAIN_CYCLES  = 120;
    localparam logic [63:0] TENTHS_PER_MS = 64'd600000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              taken;
        logic              updated;
        logic              tick;
        logic              in_range;
        logic [HELD_W-1:0] held;
    } meter_result_t;

    typedef enum logic {ROW_POLL, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   level;
        logic [TIME_W-1:0]      now_ms;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic                   typed;
        meter_result_t          want;
    } stim_row_t;

    localparam meter_result_t NO_CHECK = '0;
    localparam int            DIRECTED_ROWS = 30;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_POLL, 1'b1, 32'd0,      CFG_MIN_GAP, 20'd0, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
        '{ROW_POLL, 1'b0, 32'd100,    CFG_MIN_GAP, 20'd0, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
        '{ROW_POLL, 1'b1, 32'd500,    CFG_MIN_GAP, 20'd0, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
        '{ROW_POLL, 1'b0, 32'd1001,   CFG_MIN_GAP, 20'd0, 1'b1, '{16'd0, 1'b1, 1'b0, 1'b1, 1'b0, 7'd1}},
        '{ROW_POLL, 1'b0, 32'd1500,   CFG_MIN_GAP, 20'd0, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd1}},
        '{ROW_POLL, 1'b1, 32'd1600,   CFG_MIN_GAP, 20'd0, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd1}},
        '{ROW_POLL, 1'b0, 32'd2001,   CFG_MIN_GAP, 20'd0, 1'b1, '{16'd600, 1'b1, 1'b1, 1'b0, 1'b1, 7'd2}},
        '{ROW_POLL, 1'b1, 32'd2100,   CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b0, 32'd2101,   CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b1, 32'd2200,   CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b0, 32'd2301,   CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b1, 32'hFFFFFFF0, CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b0, 32'hFFFFFFFF, CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b1, 32'd0,      CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b0, 32'h200,    CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_REG,  1'b1, 32'd0, CFG_MIN_GAP,      20'h10000, 1'b0, NO_CHECK},
        '{ROW_REG,  1'b1, 32'd0, CFG_SPARE_5,      20'hFFFFF, 1'b0, NO_CHECK},
        '{ROW_REG,  1'b1, 32'd0, CFG_SPARE_6,      20'hAAAAA, 1'b0, NO_CHECK},
        '{ROW_REG,  1'b1, 32'd0, CFG_SPARE_7,      20'h55555, 1'b0, NO_CHECK},
        '{ROW_REG,  1'b1, 32'd0, CFG_WINDOW,       20'd0,     1'b0, NO_CHECK},
        '{ROW_REG,  1'b1, 32'd0, CFG_PERIOD,       20'd0,     1'b0, NO_CHECK},
        '{ROW_REG,  1'b1, 32'd0, CFG_RATE_FLOOR,   20'd0,     1'b0, NO_CHECK},
        '{ROW_REG,  1'b1, 32'd0, CFG_RATE_CEILING, 20'hFFFFF, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b1, 32'h1000,   CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b0, 32'h1000,   CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b1, 32'h1000,   CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b0, 32'h1000,   CFG_MIN_GAP, 20'd0, 1'b1, '{16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 7'd2}},
        '{ROW_REG,  1'b1, 32'd0, CFG_WINDOW,       20'hFFFFF, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b1, 32'h1001,   CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK},
        '{ROW_POLL, 1'b0, 32'h1001,   CFG_MIN_GAP, 20'd0, 1'b0, NO_CHECK}
    };

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    logic          offer_typed = 1'b0;
    meter_result_t offer_want  = '0;
    logic          calm        = 1'b0;
    logic          hold_req    = 1'b0;
    int            fault_count = 0;
    logic [31:0]   tap_now;
    logic          tap_level;

    meter_result_t pending_readings [$];

    logic [TIME_W-1:0]   beat_ring [RING_DEPTH];
    int unsigned         ring_count;
    int unsigned         ring_head;
    logic [TIME_W-1:0]   last_beat;
    logic [TIME_W-1:0]   last_report;
    logic                armed;
    logic [RATE_W-1:0]   rate_held;
    logic [GAP_W-1:0]    gap_cfg;
    logic [WIN_W-1:0]    window_cfg;
    logic [PERIOD_W-1:0] period_cfg;
    logic [RATE_W-1:0]   floor_cfg;
    logic [RATE_W-1:0]   ceil_cfg;

    tap_pulse_rate_meter_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic meter_result_t meter_poll(input logic level, input logic [TIME_W-1:0] now);
        meter_result_t     r;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] span;
        logic [63:0]       quot;
        r = '0;
        if (!level && !armed) begin
            armed = 1'b1;
            elapsed = now - last_beat;
            if (elapsed >= TIME_W'(gap_cfg)) begin
                last_beat = now;
                r.taken = 1'b1;
                if (ring_count < RING_DEPTH) begin
                    beat_ring[(ring_head + ring_count) % RING_DEPTH] = now;
                    ring_count++;
                end else begin
                    beat_ring[ring_head] = now;
                    ring_head = (ring_head + 1) % RING_DEPTH;
                end
                elapsed = now - beat_ring[ring_head];
                while (ring_count > 1 && elapsed > TIME_W'(window_cfg)) begin
                    ring_head = (ring_head + 1) % RING_DEPTH;
                    ring_count--;
                    elapsed = now - beat_ring[ring_head];
                end
                if (ring_count > 1) begin
                    span = beat_ring[(ring_head + ring_count - 1) % RING_DEPTH]
                           - beat_ring[ring_head];
                    if (span == '0) begin
                        rate_held = RATE_MAX;
                    end else begin
                        quot = (TENTHS_PER_MS * 64'(ring_count - 1)) / 64'(span);
                        rate_held = (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
                    end
                    r.updated = 1'b1;
                end
            end
        end
        if (level) begin
            armed = 1'b0;
        end
        elapsed = now - last_report;
        if (elapsed > TIME_W'(period_cfg)) begin
            last_report = now;
            r.tick = 1'b1;
        end
        r.rate = rate_held;
        r.in_range = (rate_held > floor_cfg) && (rate_held < ceil_cfg);
        r.held = HELD_W'(ring_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        meter_result_t reading;
        if (!i_rst_n) begin
            ring_count  = 0;
            ring_head   = 0;
            last_beat   = '0;
            last_report = '0;
            armed       = 1'b0;
            rate_held   = '0;
            gap_cfg     = MIN_GAP_RST;
            window_cfg  = WINDOW_RST;
            period_cfg  = PERIOD_RST;
            floor_cfg   = RATE_FLOOR_RST;
            ceil_cfg    = RATE_CEILING_RST;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_MIN_GAP:      gap_cfg    = i_cfg_wdata[GAP_W-1:0];
                    CFG_WINDOW:       window_cfg = i_cfg_wdata[WIN_W-1:0];
                    CFG_PERIOD:       period_cfg = i_cfg_wdata[PERIOD_W-1:0];
                    CFG_RATE_FLOOR:   floor_cfg  = i_cfg_wdata[RATE_W-1:0];
                    CFG_RATE_CEILING: ceil_cfg   = i_cfg_wdata[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                reading = meter_poll(i_s_tdata[0], i_s_tdata[TIME_W:1]);
                pending_readings.push_back(offer_typed ? offer_want : reading);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin
        meter_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_readings.size() == 0) begin
                $error("Result with no request pending: tdata %h", o_m_tdata);
                fault_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("rate_tenths", want.rate, o_m_tdata[15:0]);
                check_field("beat_taken", want.taken, o_m_tdata[16]);
                check_field("rate_updated", want.updated, o_m_tdata[17]);
                check_field("report_tick", want.tick, o_m_tdata[18]);
                check_field("rate_in_range", want.in_range, o_m_tdata[19]);
                check_field("beats_held", want.held, o_m_tdata[26:20]);
            end
        end
    end

    // The receiver stalls in short random bursts, and in one long stretch each time
    // a hold is requested, so that the block fills up and holds off its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_poll(input logic level, input logic [TIME_W-1:0] now,
                             input logic typed, input meter_result_t want);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_tvalid  <= 1'b1;
        i_s_tdata   <= {7'd0, now, level};
        offer_typed <= typed;
        offer_want  <= want;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] gap, input logic [CFG_DATA_W-1:0] win,
                              input logic [CFG_DATA_W-1:0] period,
                              input logic [CFG_DATA_W-1:0] lo_rate,
                              input logic [CFG_DATA_W-1:0] hi_rate);
        write_reg(CFG_MIN_GAP, gap);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_RATE_FLOOR, lo_rate);
        write_reg(CFG_RATE_CEILING, hi_rate);
    endtask

    // Mostly clean press and release pairs spaced lo..hi ms apart, mixed with
    // bounces, long silences, repeated timestamps and arbitrary times.
    task automatic run_taps(input int count, input int unsigned lo, input int unsigned hi);
        int unsigned pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 15);
            if (pick < 11) begin
                tap_level = !tap_level;
                tap_now += tap_level ? $urandom_range(0, 20) : $urandom_range(lo, hi);
            end else if (pick < 13) begin
                tap_level = $urandom_range(0, 1);
                tap_now += $urandom_range(0, 40);
            end else if (pick == 13) begin
                tap_level = $urandom_range(0, 1);
                tap_now += $urandom_range(5000, 40000);
            end else if (pick == 14) begin
                tap_level = $urandom_range(0, 1);
            end else begin
                tap_level = $urandom_range(0, 1);
                tap_now = $urandom();
            end
            send_poll(tap_level, tap_now, 1'b0, NO_CHECK);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_REG) begin
                write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_val);
            end else begin
                send_poll(DIRECTED[r].level, DIRECTED[r].now_ms, DIRECTED[r].typed,
                          DIRECTED[r].want);
            end
        end

        tap_now   = 32'h2000;
        tap_level = 1'b1;
        set_limits(MIN_GAP_RST, WINDOW_RST, PERIOD_RST, RATE_FLOOR_RST, RATE_CEILING_RST);
        hold_req = 1'b1;
        run_taps(130, 250, 1100);

        set_limits(20'd0, 20'd2000, 20'd0, 20'd0, 20'hFFFF);
        run_taps(100, 0, 150);

        set_limits(20'hFFFF, 20'hFFFFF, 20'hFFFF, 20'hFFFF, 20'd0);
        tap_now = 32'hFFF0_0000;
        run_taps(60, 30000, 70000);

        set_limits($urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                   $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                   $urandom_range(0, 20'hFFFFF));
        run_taps(90, 20, 900);

        set_limits(20'd50, 20'd1500, 20'd200, 20'd1000, 20'd5000);
        hold_req = 1'b1;
        run_taps(80, 20, 300);

        set_limits(MIN_GAP_RST, WINDOW_RST, PERIOD_RST, RATE_FLOOR_RST, RATE_CEILING_RST);
        calm = 1'b1;
        run_taps(65, 250, 1100);

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
